// ===== design/ppc_pkg.sv =====
// Shared types and constants for the proximity point clustering block.
// No dependencies; every other file of the block depends on this package.
package ppc_pkg;

	// default sizing, used as the defaults of the top level parameters
	localparam int MAX_POINTS_DEF = 64;
	localparam int COORD_BITS_DEF = 12;

	// join distance register
	localparam int JOIN_BITS = 12;
	localparam logic [JOIN_BITS-1:0] JOIN_RESET = 12'd192;
	localparam int LIMIT_BITS = 2 * JOIN_BITS;

	// result label field
	localparam int GROUP_ID_BITS = 6;
	localparam int GROUP_ID_MAX = 63;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQR,
		ST_HIT,
		ST_WALK,
		ST_DONE
	} ppc_state_t;

	// strobes broadcast from the sequencer to every cell
	typedef struct packed {
		logic sq_en;
		logic hit_en;
		logic wr_en;
	} ppc_ctrl_t;

endpackage

// ===== design/ppc_point_if.sv =====
// Point request channel: valid/ready handshake with the coordinate payload.
// Depends on ppc_pkg for the default coordinate width.
interface ppc_point_if #(
	parameter int COORD_BITS = ppc_pkg::COORD_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] point_x;
	logic [COORD_BITS-1:0] point_y;
	logic                  first;

	modport source (output valid, output point_x, output point_y, output first, input ready);
	modport sink   (input valid, input point_x, input point_y, input first, output ready);
endinterface

// ===== design/ppc_result_if.sv =====
// Result request channel: valid/ready handshake with the group label payload.
// Depends on ppc_pkg for the label width.
interface ppc_result_if;
	logic                               valid;
	logic                               ready;
	logic [ppc_pkg::GROUP_ID_BITS-1:0]  group_id;
	logic                               new_group;
	logic                               dropped;

	modport source (output valid, output group_id, output new_group, output dropped, input ready);
	modport sink   (input valid, input group_id, input new_group, input dropped, output ready);
endinterface

// ===== design/ppc_cell.sv =====
// One cell of the point store: holds one point and its group label, tests it
// against the current point and folds its hit into the group search chain.
// Depends on ppc_pkg.
module ppc_cell #(
	parameter int IDX        = 0,
	parameter int COORD_BITS = ppc_pkg::COORD_BITS_DEF,
	parameter int CW         = 7,
	parameter int LW         = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ppc_pkg::ppc_ctrl_t          ctrl,
	input  logic [COORD_BITS-1:0]       px,
	input  logic [COORD_BITS-1:0]       py,
	input  logic [ppc_pkg::LIMIT_BITS-1:0] limit,
	input  logic [CW-1:0]               count,
	input  logic [CW-1:0]               wr_ptr,
	input  logic [LW-1:0]               wr_grp,
	input  logic                        prev_found,
	input  logic [LW-1:0]               prev_best,
	output logic                        found,
	output logic [LW-1:0]               best
);
	import ppc_pkg::*;

	localparam int SQ_BITS  = 2 * COORD_BITS;
	localparam int SUM_BITS = SQ_BITS + 1;
	localparam int CMP_BITS = (SUM_BITS > LIMIT_BITS) ? SUM_BITS : LIMIT_BITS;

	logic [COORD_BITS-1:0] sx_q, sy_q;
	logic [LW-1:0]         grp_q;
	logic [COORD_BITS-1:0] dx, dy;
	logic [SQ_BITS-1:0]    dxsq_s1, dysq_s1;
	logic [SUM_BITS-1:0]   dsq;
	logic                  entry_valid;
	logic                  hit_s2;
	logic                  take;
	logic                  found_q;
	logic [LW-1:0]         best_q;

	// entry holds a point while its index is below the fill count
	assign entry_valid = CW'(IDX) < count;

	// absolute coordinate differences
	assign dx = (px > sx_q) ? (px - sx_q) : (sx_q - px);
	assign dy = (py > sy_q) ? (py - sy_q) : (sy_q - py);

	// square the differences
	always_ff @(posedge clk) begin
		if (ctrl.sq_en) begin
			dxsq_s1 <= SQ_BITS'(dx) * SQ_BITS'(dx);
			dysq_s1 <= SQ_BITS'(dy) * SQ_BITS'(dy);
		end
	end

	// sum and compare against the squared join distance
	assign dsq = SUM_BITS'(dxsq_s1) + SUM_BITS'(dysq_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s2 <= 1'b0;
		end else if (ctrl.hit_en) begin
			hit_s2 <= entry_valid && (CMP_BITS'(dsq) < CMP_BITS'(limit));
		end
	end

	// fold this cell into the lowest-group search and hand it on
	assign take = hit_s2 && (!prev_found || (grp_q < prev_best));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			best_q  <= '0;
		end else begin
			found_q <= prev_found | hit_s2;
			best_q  <= take ? grp_q : prev_best;
		end
	end

	assign found = found_q;
	assign best  = best_q;

	// store the point when the write pointer selects this cell
	always_ff @(posedge clk) begin
		if (ctrl.wr_en && (wr_ptr == CW'(IDX))) begin
			sx_q  <= px;
			sy_q  <= py;
			grp_q <= wr_grp;
		end
	end

endmodule

// ===== design/proximity_point_clustering.sv =====
// Proximity point clustering: a chain of MAX_POINTS cells, one stored point each.
// A new point is accepted only in the idle state, after the previous point's
// result has been registered; the group search walks the cell chain one cell
// per cycle.
// Reset: fill and group counts clear, join distance returns to 192; stored
// points are not cleared, the fill count masks them. Depends on ppc_pkg.
module proximity_point_clustering #(
	parameter int MAX_POINTS = ppc_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = ppc_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ppc_pkg::JOIN_BITS-1:0] cfg_wdata,
	ppc_point_if.sink                     points,
	ppc_result_if.source                  results
);
	import ppc_pkg::*;

	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int LW = $clog2(MAX_POINTS);
	localparam int XW = (CW > GROUP_ID_BITS) ? CW : GROUP_ID_BITS;

	ppc_state_t            state_q, state_d;
	ppc_ctrl_t             ctrl;
	logic [JOIN_BITS-1:0]  join_q;
	logic [LIMIT_BITS-1:0] limit_q;
	logic [COORD_BITS-1:0] px_q, py_q;
	logic [CW-1:0]         count_q, gcount_q;
	logic [LW-1:0]         walk_q;
	logic                  accept;
	logic                  walk_last;
	logic                  out_free;
	logic                  finish;
	logic                  full;
	logic                  chain_found;
	logic [CW-1:0]         label;
	logic [XW-1:0]         label_x;
	logic [GROUP_ID_BITS-1:0] label_sat;
	logic                  out_valid_q;
	logic [GROUP_ID_BITS-1:0] out_group_q;
	logic                  out_new_q, out_drop_q;
	logic                  found_w [0:MAX_POINTS];
	logic [LW-1:0]         best_w  [0:MAX_POINTS];

	// join distance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			join_q <= JOIN_RESET;
		end else if (cfg_we) begin
			join_q <= cfg_wdata;
		end
	end

	// sequencer: next state and cell strobes
	assign accept    = points.valid && points.ready;
	assign walk_last = walk_q == LW'(MAX_POINTS - 1);
	assign out_free  = !out_valid_q || results.ready;

	always_comb begin
		state_d      = state_q;
		ctrl         = '0;
		points.ready = 1'b0;
		finish       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				points.ready = 1'b1;
				if (points.valid) state_d = ST_SQR;
			end
			ST_SQR: begin
				ctrl.sq_en = 1'b1;
				state_d    = ST_HIT;
			end
			ST_HIT: begin
				ctrl.hit_en = 1'b1;
				state_d     = ST_WALK;
			end
			ST_WALK: begin
				if (walk_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					finish      = 1'b1;
					ctrl.wr_en  = !full;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// classify from the end of the chain
	assign chain_found = found_w[MAX_POINTS];
	assign full        = count_q >= CW'(MAX_POINTS);
	assign label       = chain_found ? CW'(best_w[MAX_POINTS]) : gcount_q;
	assign label_x     = XW'(label);
	assign label_sat   = (label_x > XW'(GROUP_ID_MAX)) ?
		GROUP_ID_BITS'(GROUP_ID_MAX) : GROUP_ID_BITS'(label_x);

	// state, latched point, counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			gcount_q <= '0;
			walk_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept && points.first) begin
				count_q  <= '0;
				gcount_q <= '0;
			end else if (finish && !full) begin
				count_q <= count_q + CW'(1);
				if (!chain_found) gcount_q <= gcount_q + CW'(1);
			end
			if (state_q == ST_WALK) begin
				walk_q <= walk_q + LW'(1);
			end else begin
				walk_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_q    <= points.point_x;
			py_q    <= points.point_y;
			limit_q <= LIMIT_BITS'(join_q) * LIMIT_BITS'(join_q);
		end
	end

	// cell chain; the head starts with no hit
	assign found_w[0] = 1'b0;
	assign best_w[0]  = '0;

	for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
		ppc_cell #(
			.IDX        (i),
			.COORD_BITS (COORD_BITS),
			.CW         (CW),
			.LW         (LW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.px         (px_q),
			.py         (py_q),
			.limit      (limit_q),
			.count      (count_q),
			.wr_ptr     (count_q),
			.wr_grp     (LW'(label)),
			.prev_found (found_w[i]),
			.prev_best  (best_w[i]),
			.found      (found_w[i+1]),
			.best       (best_w[i+1])
		);
	end

	// output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_group_q <= label_sat;
			out_new_q   <= !chain_found;
			out_drop_q  <= full;
		end
	end

	assign results.valid     = out_valid_q;
	assign results.group_id  = out_group_q;
	assign results.new_group = out_new_q;
	assign results.dropped   = out_drop_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_POINTS))
		else $error("fill count above store depth");

	a_group_bound: assert property (@(posedge clk) disable iff (!arst_n)
		gcount_q <= count_q)
		else $error("more groups than stored points");

	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(results.valid) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside of finish");

	a_store_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && !full && !(accept && points.first)) |=> count_q == $past(count_q) + CW'(1))
		else $error("stored point not counted");
`endif

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for proximity_point_clustering: predicts the group label of each point.
// Depends on ppc_pkg, ppc_point_if, ppc_result_if and the proximity_point_clustering design.
module testbench;
	import ppc_pkg::*;

	localparam int STORE_DEPTH = MAX_POINTS_DEF;
	localparam int COORD_W = COORD_BITS_DEF;
	localparam int COORD_MAX = (1 << COORD_W) - 1;
	localparam int JOIN_MAX = (1 << JOIN_BITS) - 1;
	localparam int LATENCY = STORE_DEPTH + 3;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		logic [GROUP_ID_BITS-1:0] group_id;
		logic                     new_group;
		logic                     dropped;
	} label_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [JOIN_BITS-1:0] cfg_wdata;

	ppc_point_if #(.COORD_BITS(COORD_W)) point_bus ();
	ppc_result_if result_bus ();

	proximity_point_clustering #(
		.MAX_POINTS(STORE_DEPTH),
		.COORD_BITS(COORD_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.points(point_bus),
		.results(result_bus)
	);

	// shadow copy of the point store and the distance register
	logic [COORD_W-1:0]   shadow_x [STORE_DEPTH];
	logic [COORD_W-1:0]   shadow_y [STORE_DEPTH];
	int unsigned          shadow_group [STORE_DEPTH];
	int unsigned          fill_count;
	int unsigned          group_total;
	logic [JOIN_BITS-1:0] join_dist;

	label_t pending_labels[$];

	int send_idle_pct;
	int recv_idle_pct;
	int points_sent;
	int labels_checked;
	int join_writes;
	int overflow_points;
	int mismatch_count;
	int stall_cycles;

	always #1 clk = ~clk;

	// Classify one point against the shadow store and update it, as the block does.
	function automatic label_t classify_point(input logic [COORD_W-1:0] px,
			input logic [COORD_W-1:0] py, input logic restart);
		label_t      res;
		bit          found;
		bit          full;
		int unsigned best;
		int unsigned label;
		longint      dx;
		longint      dy;
		longint      limit;
		if (restart) begin
			fill_count = 0;
			group_total = 0;
		end
		found = 1'b0;
		best = 0;
		limit = longint'(join_dist) * longint'(join_dist);
		for (int i = 0; i < fill_count; i++) begin
			dx = (px > shadow_x[i]) ? px - shadow_x[i] : shadow_x[i] - px;
			dy = (py > shadow_y[i]) ? py - shadow_y[i] : shadow_y[i] - py;
			if (dx * dx + dy * dy < limit) begin
				if (!found || shadow_group[i] < best)
					best = shadow_group[i];
				found = 1'b1;
			end
		end
		full = (fill_count >= STORE_DEPTH);
		label = found ? best : group_total;
		if (!full) begin
			shadow_x[fill_count] = px;
			shadow_y[fill_count] = py;
			shadow_group[fill_count] = label;
			fill_count++;
			if (!found)
				group_total++;
		end
		res.group_id = (label > GROUP_ID_MAX) ? GROUP_ID_MAX[GROUP_ID_BITS-1:0]
			: label[GROUP_ID_BITS-1:0];
		res.new_group = !found;
		res.dropped = full;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("ERROR %0t ns: %s got %0d, want %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// Send one point request, idling first at the current rate; predict at accept.
	task automatic send_point(input int px, input int py, input bit restart);
		label_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			point_bus.valid <= 1'b0;
			@(posedge clk);
		end
		point_bus.valid <= 1'b1;
		point_bus.point_x <= px[COORD_W-1:0];
		point_bus.point_y <= py[COORD_W-1:0];
		point_bus.first <= restart;
		@(posedge clk);
		while (!point_bus.ready)
			@(posedge clk);
		predicted = classify_point(px[COORD_W-1:0], py[COORD_W-1:0], restart);
		pending_labels = {pending_labels, predicted};
		points_sent++;
		if (predicted.dropped)
			overflow_points++;
	endtask

	// Hold the sender until every label is back; optionally let the pipeline settle.
	task automatic wait_for_labels(input bit settle);
		point_bus.valid <= 1'b0;
		while (pending_labels.size() != 0)
			@(posedge clk);
		if (settle)
			repeat (LATENCY) @(posedge clk);
	endtask

	// Drain the block, then write the join distance.
	task automatic set_join(input int value);
		wait_for_labels(1'b1);
		cfg_we <= 1'b1;
		cfg_wdata <= value[JOIN_BITS-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		join_dist = value[JOIN_BITS-1:0];
		join_writes++;
	endtask

	function automatic int near_coord(input int center, input int spread);
		int v;
		v = center + int'($urandom_range(2 * spread)) - spread;
		if (v < 0)
			v = 0;
		if (v > COORD_MAX)
			v = COORD_MAX;
		return v;
	endfunction

	function automatic int pick_join();
		case ($urandom_range(7))
			0: return JOIN_MAX;
			1: return 1;
			2: return int'(JOIN_RESET);
			3: return $urandom_range(JOIN_MAX);
			default: return $urandom_range(16, 400);
		endcase
	endfunction

	// Field extremes: four corners, all far apart at the reset distance.
	task automatic test_corners();
		send_point(0, 0, 1'b1);
		send_point(COORD_MAX, COORD_MAX, 1'b0);
		send_point(0, COORD_MAX, 1'b0);
		send_point(COORD_MAX, 0, 1'b0);
	endtask

	// Distance equal to the threshold opens a group; one below joins the oldest group.
	task automatic test_threshold();
		send_point(100, 100, 1'b1);
		send_point(100 + int'(JOIN_RESET), 100, 1'b0);
		send_point(100 + int'(JOIN_RESET) - 1, 100, 1'b0);
		send_point(2000, 2000, 1'b1);
		send_point(2100, 2150, 1'b0);
	endtask

	// A point close to two groups joins the older one; the groups stay apart.
	task automatic test_no_merge();
		send_point(1000, 1000, 1'b1);
		send_point(1300, 1000, 1'b0);
		send_point(1150, 1000, 1'b0);
		send_point(1400, 1000, 1'b0);
	endtask

	// Zero distance: even an identical point opens its own group.
	task automatic test_zero_distance();
		set_join(0);
		send_point(500, 500, 1'b1);
		send_point(500, 500, 1'b0);
		send_point(501, 500, 1'b0);
	endtask

	// Largest distance: only points at least the full range apart stay separate.
	task automatic test_max_distance();
		set_join(JOIN_MAX);
		send_point(0, 0, 1'b1);
		send_point(COORD_MAX, COORD_MAX, 1'b0);
		send_point(COORD_MAX, 0, 1'b0);
		send_point(2048, 2048, 1'b0);
	endtask

	// Fill the store, then keep sending so points are classified but dropped.
	task automatic test_store_full(input int join_value, input int extra);
		set_join(join_value);
		send_point($urandom_range(COORD_MAX), $urandom_range(COORD_MAX), 1'b1);
		for (int i = 1; i < STORE_DEPTH + extra; i++)
			send_point($urandom_range(COORD_MAX), $urandom_range(COORD_MAX), 1'b0);
	endtask

	// Clustered frames of random size; some overflow, some skip the restart flag.
	task automatic run_clusters(input int n_items);
		int done;
		int frame_len;
		int n_centers;
		int ci;
		int spread;
		int cx [8];
		int cy [8];
		bit restart;
		done = 0;
		spread = int'(join_dist) * 3 / 2 + 4;
		if (spread > 2047)
			spread = 2047;
		while (done < n_items) begin
			frame_len = ($urandom_range(7) == 0) ? $urandom_range(60, 90) : $urandom_range(2, 40);
			n_centers = $urandom_range(1, 8);
			for (int c = 0; c < n_centers; c++) begin
				cx[c] = $urandom_range(COORD_MAX);
				cy[c] = $urandom_range(COORD_MAX);
			end
			for (int i = 0; i < frame_len && done < n_items; i++) begin
				restart = (i == 0 && $urandom_range(9) != 0) || ($urandom_range(39) == 0);
				if ($urandom_range(4) == 0) begin
					send_point($urandom_range(COORD_MAX), $urandom_range(COORD_MAX), restart);
				end else begin
					ci = $urandom_range(n_centers - 1);
					send_point(near_coord(cx[ci], spread), near_coord(cy[ci], spread), restart);
				end
				done++;
				if ($urandom_range(149) == 0)
					wait_for_labels(1'b0);
			end
		end
	endtask

	task automatic test_random_phase(input int send_pct, input int recv_pct, input int n_items);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		set_join(pick_join());
		run_clusters(n_items / 2);
		set_join(pick_join());
		run_clusters(n_items - n_items / 2);
	endtask

	// Randomly stall the result side at the current rate.
	always @(posedge clk)
		result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);

	// Compare each accepted label with the oldest prediction.
	always @(posedge clk) begin
		label_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (pending_labels.size() == 0) begin
				report_mismatch("label with no point pending, group_id", result_bus.group_id, 0);
			end else begin
				want = pending_labels.pop_front();
				labels_checked++;
				if (result_bus.group_id !== want.group_id)
					report_mismatch("group_id", result_bus.group_id, want.group_id);
				if (result_bus.new_group !== want.new_group)
					report_mismatch("new_group", result_bus.new_group, want.new_group);
				if (result_bus.dropped !== want.dropped)
					report_mismatch("dropped", result_bus.dropped, want.dropped);
			end
		end
	end

	// End the run when no request moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (point_bus.valid && point_bus.ready)
				|| (result_bus.valid && result_bus.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("ERROR %0t ns: no request moved for %0d cycles, %0d labels outstanding",
				$time, stall_cycles, pending_labels.size());
			$display("Mismatches found");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		point_bus.valid = 1'b0;
		point_bus.point_x = '0;
		point_bus.point_y = '0;
		point_bus.first = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		fill_count = 0;
		group_total = 0;
		join_dist = JOIN_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_corners();
		test_threshold();
		test_no_merge();
		test_zero_distance();
		test_max_distance();
		test_store_full(0, 6);
		test_store_full(int'(JOIN_RESET), 6);
		test_random_phase(11, 86, 370);
		test_random_phase(86, 11, 370);
		test_random_phase(0, 0, 370);
		wait_for_labels(1'b1);

		$display("Run covered %0d points and %0d labels over %0d distance settings,",
			points_sent, labels_checked, join_writes);
		$display("including %0d points sent while the store was full.", overflow_points);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
